// File: rtl/fisn_pkg.sv
// package: binary32 arithmetic helpers and payload types for the normalize pipeline
`default_nettype none
package fisn_pkg;

   localparam int unsigned NumStages = 9;
   localparam logic [31:0] MagicGuess = 32'h5f375a86;
   localparam logic [31:0] OneHalf    = 32'h3f000000;
   localparam logic [31:0] ThreeHalf  = 32'h3fc00000;
   localparam logic [31:0] QuietNan   = 32'h7fc00000;
   localparam logic [30:0] InfMag     = 31'h7f800000;

   typedef struct packed {
      logic        op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] p;
      logic [31:0] q;
      logic [31:0] w;
   } stage_type;

   function automatic logic [31:0] rsqrt_guess(input logic [31:0] u);
      return MagicGuess - {u[31], u[31:1]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic              sr;
      logic [7:0]        eaf;
      logic [7:0]        ebf;
      logic [23:0]       ma;
      logic [23:0]       mb;
      logic [47:0]       pr;
      logic [47:0]       pn;
      logic [5:0]        lz;
      logic signed [10:0] e;
      logic [10:0]       shamt;
      logic              st;
      logic [23:0]       mt;
      logic              up;
      logic [7:0]        ef;
      logic              anan;
      logic              bnan;
      logic              ainf;
      logic              binf;
      logic              azero;
      logic              bzero;
      logic [31:0]       r;
      sr    = a[31] ^ b[31];
      anan  = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      bnan  = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      ainf  = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      binf  = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      azero = (a[30:0] == 31'd0);
      bzero = (b[30:0] == 31'd0);
      eaf   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      ebf   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma    = {(a[30:23] != 8'd0), a[22:0]};
      mb    = {(b[30:23] != 8'd0), b[22:0]};
      pr    = 48'(ma) * 48'(mb);
      lz    = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (pr[i]) lz = 6'(47 - i);
      end
      pn    = pr << lz;
      e     = $signed({3'b000, eaf}) + $signed({3'b000, ebf}) - 11'sd126
              - $signed({5'b00000, lz});
      st    = 1'b0;
      ef    = 8'd0;
      shamt = 11'd0;
      if (e <= 0) begin
         shamt = 11'(11'sd1 - e);
         if (shamt >= 11'd48) begin
            st = |pn;
            pn = 48'd0;
         end else begin
            st = |(pn & ~({48{1'b1}} << shamt[5:0]));
            pn = pn >> shamt[5:0];
         end
      end else begin
         ef = e[7:0];
      end
      mt = pn[47:24];
      st = st | (|pn[22:0]);
      up = pn[23] & (st | mt[0]);
      r  = {sr, ({(mt[23] ? ef : 8'd0), mt[22:0]} + 31'(up))};
      if (anan || bnan || (ainf && bzero) || (binf && azero)) begin
         r = QuietNan;
      end else if (ainf || binf || (e >= 11'sd255)) begin
         r = {sr, InfMag};
      end else if (azero || bzero) begin
         r = {sr, 31'd0};
      end
      return r;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic [7:0]  exf;
      logic [7:0]  eyf;
      logic [7:0]  d;
      logic [26:0] mx;
      logic [26:0] my;
      logic [26:0] mys;
      logic [27:0] s;
      logic [4:0]  pos;
      logic [26:0] n;
      logic [8:0]  e;
      logic [7:0]  lsh;
      logic [23:0] mt;
      logic        up;
      logic        anan;
      logic        bnan;
      logic        ainf;
      logic        binf;
      logic [31:0] r;
      anan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      bnan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      ainf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
      binf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
      if (a[30:0] >= b[30:0]) begin
         x = a;
         y = b;
      end else begin
         x = b;
         y = a;
      end
      exf = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      eyf = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      mx  = {(x[30:23] != 8'd0), x[22:0], 3'b000};
      my  = {(y[30:23] != 8'd0), y[22:0], 3'b000};
      d   = exf - eyf;
      if (d >= 8'd27) begin
         mys = {26'd0, |my};
      end else begin
         mys = (my >> d[4:0]) | 27'(|(my & ~({27{1'b1}} << d[4:0])));
      end
      if (x[31] == y[31]) s = {1'b0, mx} + {1'b0, mys};
      else                s = {1'b0, mx} - {1'b0, mys};
      pos = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (s[i]) pos = 5'(i);
      end
      lsh = 8'd0;
      if (pos == 5'd27) begin
         n = s[27:1] | 27'(s[0]);
         e = {1'b0, exf} + 9'd1;
      end else begin
         lsh = 8'(5'd26 - pos);
         if (lsh > exf - 8'd1) lsh = exf - 8'd1;
         n = s[26:0] << lsh[4:0];
         e = {1'b0, exf} - {1'b0, lsh};
      end
      mt = n[26:3];
      up = n[2] & (n[1] | n[0] | mt[0]);
      r  = {x[31], ({(mt[23] ? e[7:0] : 8'd0), mt[22:0]} + 31'(up))};
      if (anan || bnan || (ainf && binf && (a[31] != b[31]))) begin
         r = QuietNan;
      end else if (ainf || binf) begin
         r = x;
      end else if (s == 28'd0) begin
         r = {(x[31] & y[31]), 31'd0};
      end else if (e >= 9'd255) begin
         r = {x[31], InfMag};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/fisn_if.sv
// interfaces: request and response channels of the normalize pipeline
`default_nettype none
interface fisn_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] a_bits;
   logic [31:0] b_bits;
   logic [31:0] c_bits;
   modport source (output valid, op, a_bits, b_bits, c_bits, input ready);
   modport sink   (input valid, op, a_bits, b_bits, c_bits, output ready);
endinterface

interface fisn_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] r0_bits;
   logic [31:0] r1_bits;
   logic [31:0] r2_bits;
   modport source (output valid, r0_bits, r1_bits, r2_bits, input ready);
   modport sink   (input valid, r0_bits, r1_bits, r2_bits, output ready);
endinterface
`default_nettype wire

// File: rtl/fast_inverse_sqrt_normalize.sv
// top level: pipelined approximate inverse square root and 3-vector normalization
//
// req_ch carries op, a_bits, b_bits, c_bits; rsp_ch returns r0_bits..r2_bits.
// a transaction moves on a rising clock edge with valid and ready both high.
// op 0 gives the approximate inverse square root of a in r0 (r1, r2 zero);
// op 1 scales (a,b,c) by the inverse square root of its squared length.
// nine register stages of binary32 multiplies and adds: squares, two adds,
// half and first guess, two products, subtract from 1.5, newton product and
// the final component scaling. while the receiver keeps rsp_ch.ready high,
// one transaction per cycle is sustained. each stage has its own valid bit
// and takes new data when empty or when the next stage moves, so bubbles
// close up while the receiver stalls and the input keeps being accepted
// until every stage is full; nothing is lost or repeated. synchronous reset
// clears the valid bits only.
`default_nettype none
module fast_inverse_sqrt_normalize
   import fisn_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   fisn_req_if.sink    req_ch,
   fisn_rsp_if.source  rsp_ch
);

   stage_type              st_ff [1:NumStages];
   stage_type              st_in [1:NumStages];
   logic [NumStages:1]     vld_ff;
   logic [NumStages+1:1]   rdy;
   logic [31:0]            v4;
   logic [31:0]            k9;

   always_comb begin
      rdy[NumStages+1] = rsp_ch.ready;
      for (int i = NumStages; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end
   assign req_ch.ready = rdy[1];

   always_comb begin
      st_in[1].op = req_ch.op;
      st_in[1].a  = req_ch.a_bits;
      st_in[1].b  = req_ch.b_bits;
      st_in[1].c  = req_ch.c_bits;
      st_in[1].p  = fp_mul(req_ch.a_bits, req_ch.a_bits);
      st_in[1].q  = fp_mul(req_ch.b_bits, req_ch.b_bits);
      st_in[1].w  = fp_mul(req_ch.c_bits, req_ch.c_bits);

      st_in[2]   = st_ff[1];
      st_in[2].p = fp_add(st_ff[1].p, st_ff[1].q);

      st_in[3]   = st_ff[2];
      st_in[3].p = fp_add(st_ff[2].p, st_ff[2].w);

      v4         = st_ff[3].op ? st_ff[3].p : st_ff[3].a;
      st_in[4]   = st_ff[3];
      st_in[4].p = fp_mul(OneHalf, v4);
      st_in[4].q = rsqrt_guess(v4);

      st_in[5]   = st_ff[4];
      st_in[5].p = fp_mul(st_ff[4].p, st_ff[4].q);

      st_in[6]   = st_ff[5];
      st_in[6].p = fp_mul(st_ff[5].p, st_ff[5].q);

      st_in[7]   = st_ff[6];
      st_in[7].p = fp_add(ThreeHalf, {~st_ff[6].p[31], st_ff[6].p[30:0]});

      st_in[8]   = st_ff[7];
      st_in[8].p = fp_mul(st_ff[7].q, st_ff[7].p);

      k9         = st_ff[8].p;
      st_in[9]   = st_ff[8];
      if (st_ff[8].op) begin
         st_in[9].p = fp_mul(st_ff[8].a, k9);
         st_in[9].q = fp_mul(st_ff[8].b, k9);
         st_in[9].w = fp_mul(st_ff[8].c, k9);
      end else begin
         st_in[9].p = k9;
         st_in[9].q = 32'd0;
         st_in[9].w = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[1]) vld_ff[1] <= req_ch.valid;
         for (int i = 2; i <= NumStages; i++) begin
            if (rdy[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NumStages; i++) begin
         if (rdy[i]) st_ff[i] <= st_in[i];
      end
   end

   assign rsp_ch.valid   = vld_ff[NumStages];
   assign rsp_ch.r0_bits = st_ff[NumStages].p;
   assign rsp_ch.r1_bits = st_ff[NumStages].q;
   assign rsp_ch.r2_bits = st_ff[NumStages].w;

endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench: scoreboard check of the inverse square root and vector normalize pipeline
`timescale 1ns / 1ps
module tb;
   import fisn_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned RandomItems = 1030;

   class rsqrt_scoreboard;
      typedef struct {
         logic [31:0] r0;
         logic [31:0] r1;
         logic [31:0] r2;
      } norm_result_type;

      norm_result_type pending[$];
      int unsigned errors;
      int unsigned matched;
      int unsigned noted_ops[2];

      function new();
         errors = 0;
         matched = 0;
         noted_ops[0] = 0;
         noted_ops[1] = 0;
      endfunction

      // exact widening of a binary32 pattern to a real
      function real widen(logic [31:0] u);
         logic [23:0] mm;
         int ex;
         logic [63:0] d;
         if (u[30:23] == 8'hff) begin
            d = {u[31], 11'h7ff, (u[22:0] != 23'd0), 51'd0};
         end else if (u[30:0] == 31'd0) begin
            d = {u[31], 63'd0};
         end else if (u[30:23] == 8'd0) begin
            mm = {1'b0, u[22:0]};
            ex = -126;
            while (!mm[23]) begin
               mm = mm << 1;
               ex--;
            end
            d = {u[31], 11'(ex + 1023), mm[22:0], 29'd0};
         end else begin
            d = {u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'd0};
         end
         return $bitstoreal(d);
      endfunction

      // round a real to binary32, nearest even, with subnormals
      function logic [31:0] narrow(real v);
         logic [63:0] d;
         logic [63:0] sig;
         logic [63:0] keep;
         logic [63:0] rem;
         logic [63:0] half;
         logic [31:0] mag;
         logic s;
         int e;
         int fe;
         int sh;
         d = $realtobits(v);
         s = d[63];
         e = int'(d[62:52]);
         if (e == 2047) return (d[51:0] != 0) ? QuietNan : {s, InfMag};
         if (e == 0) return {s, 31'd0};
         sig = {11'd0, 1'b1, d[51:0]};
         fe = e - 1023 + 127;
         if (fe >= 255) return {s, InfMag};
         sh = (fe >= 1) ? 29 : 30 - fe;
         if (sh > 60) return {s, 31'd0};
         keep = sig >> sh;
         rem = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
         if (fe >= 1) mag = 32'((fe - 1) << 23) + keep[31:0];
         else mag = keep[31:0];
         if (mag >= {1'b0, InfMag}) return {s, InfMag};
         return {s, mag[30:0]};
      endfunction

      function logic [31:0] mul32(logic [31:0] x, logic [31:0] y);
         return narrow(widen(x) * widen(y));
      endfunction

      function logic [31:0] add32(logic [31:0] x, logic [31:0] y);
         return narrow(widen(x) + widen(y));
      endfunction

      function logic [31:0] approx_inv_root(logic [31:0] v);
         logic [31:0] hv;
         logic [31:0] g;
         logic [31:0] t;
         hv = mul32(OneHalf, v);
         g = MagicGuess - {v[31], v[31:1]};
         t = mul32(hv, g);
         t = mul32(t, g);
         t = add32(ThreeHalf, {~t[31], t[30:0]});
         return mul32(g, t);
      endfunction

      function logic [31:0] canon(logic [31:0] u);
         if (u[30:23] == 8'hff && u[22:0] != 23'd0) return QuietNan;
         return u;
      endfunction

      function void note(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
         norm_result_type r;
         logic [31:0] len2;
         logic [31:0] k;
         if (!op) begin
            r.r0 = canon(approx_inv_root(a));
            r.r1 = 32'd0;
            r.r2 = 32'd0;
         end else begin
            len2 = add32(add32(mul32(a, a), mul32(b, b)), mul32(c, c));
            k = approx_inv_root(len2);
            r.r0 = canon(mul32(a, k));
            r.r1 = canon(mul32(b, k));
            r.r2 = canon(mul32(c, k));
         end
         noted_ops[op]++;
         pending.push_back(r);
      endfunction

      function void check(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2);
         norm_result_type w;
         if (pending.size() == 0) begin
            $error("unexpected transaction r0=%h r1=%h r2=%h", r0, r1, r2);
            errors++;
            return;
         end
         w = pending.pop_front();
         matched++;
         if (r0 !== w.r0) begin
            $error("r0_bits expected %h actual %h", w.r0, r0);
            errors++;
         end
         if (r1 !== w.r1) begin
            $error("r1_bits expected %h actual %h", w.r1, r1);
            errors++;
         end
         if (r2 !== w.r2) begin
            $error("r2_bits expected %h actual %h", w.r2, r2);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycles;
   int unsigned tx_idle;
   int unsigned rx_idle;
   rsqrt_scoreboard sb;

   fisn_req_if req_ch();
   fisn_rsp_if rsp_ch();

   fast_inverse_sqrt_normalize u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note(req_ch.op, req_ch.a_bits, req_ch.b_bits, req_ch.c_bits);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check(rsp_ch.r0_bits, rsp_ch.r1_bits, rsp_ch.r2_bits);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
   end

   task automatic send_item(logic op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
      while ($urandom_range(99) < tx_idle) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.a_bits <= a;
      req_ch.b_bits <= b;
      req_ch.c_bits <= c;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         4, 5: v[30:23] = 8'($urandom_range(100, 150));
         6: v[30:23] = 8'd0;
         7: v[30:23] = 8'($urandom_range(200, 254));
         8: v[30:23] = 8'($urandom_range(1, 40));
         9: begin
            case ($urandom_range(3))
               0: v[30:0] = 31'd0;
               1: v[30:0] = InfMag;
               2: v[30:23] = 8'hff;
               default: v[30:0] = 31'h3f800000;
            endcase
         end
         default: ;
      endcase
      if ($urandom_range(3) != 0 && v[30:23] != 8'hff) v[31] = 1'b0;
      return v;
   endfunction

   initial begin
      sb = new();
      cycles = 0;
      tx_idle = 0;
      rx_idle = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = 1'b0;
      req_ch.a_bits = 32'd0;
      req_ch.b_bits = 32'd0;
      req_ch.c_bits = 32'd0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, specials, both ops
      send_item(1'b0, 32'h00000000, 32'hffffffff, 32'h12345678);
      send_item(1'b0, 32'h80000000, 32'h0, 32'h0);
      send_item(1'b0, 32'h3f800000, 32'h0, 32'h0);
      send_item(1'b0, 32'h40800000, 32'h0, 32'h0);
      send_item(1'b0, 32'h7f800000, 32'h0, 32'h0);
      send_item(1'b0, 32'hff800000, 32'h0, 32'h0);
      send_item(1'b0, 32'h7fc00001, 32'h0, 32'h0);
      send_item(1'b0, 32'h00000001, 32'h0, 32'h0);
      send_item(1'b0, 32'h007fffff, 32'h0, 32'h0);
      send_item(1'b0, 32'h7f7fffff, 32'h0, 32'h0);
      send_item(1'b0, 32'hffffffff, 32'h0, 32'h0);
      send_item(1'b0, 32'hbf800000, 32'hffffffff, 32'hffffffff);
      send_item(1'b1, 32'h00000000, 32'h00000000, 32'h00000000);
      send_item(1'b1, 32'h40400000, 32'h40800000, 32'h00000000);
      send_item(1'b1, 32'h3f800000, 32'hbf800000, 32'h3f800000);
      send_item(1'b1, 32'h7f800000, 32'h3f800000, 32'h3f800000);
      send_item(1'b1, 32'h3f800000, 32'h7fc00000, 32'h3f800000);
      send_item(1'b1, 32'h00000001, 32'h80000001, 32'h00000003);
      send_item(1'b1, 32'h7f7fffff, 32'h7f7fffff, 32'h7f7fffff);
      send_item(1'b1, 32'h20000000, 32'h1f800000, 32'h00400000);
      send_item(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(1'b1, 32'h5f000000, 32'h80000000, 32'h00000000);

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle = (ph == 0) ? 27 : (ph == 1) ? 87 : 0;
         rx_idle = (ph == 0) ? 87 : (ph == 1) ? 27 : 0;
         for (int i = 0; i < RandomItems / 3; i++)
            send_item(1'($urandom_range(1)), pick_value(), pick_value(), pick_value());
      end
      req_ch.valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (3 * NumStages) @(posedge clock);

      $display("checked %0d transactions: %0d inverse square root, %0d normalize",
               sb.matched, sb.noted_ops[0], sb.noted_ops[1]);
      $display("sender and receiver stalls swept in three phases, %0d cycles", cycles);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/fisn_pkg.sv
rtl/fisn_if.sv
rtl/fast_inverse_sqrt_normalize.sv
tb/tb.sv
